// ----- rtl/sample_stats_percentile_defines.svh -----
// assertion macros for the sample statistics block
// used by sample_stats_percentile; expects clk and rst in scope
`ifndef SAMPLE_STATS_PERCENTILE_DEFINES_SVH
`define SAMPLE_STATS_PERCENTILE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define SPS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// property that must hold in the cycle after its trigger
`define SPS_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
// shared constants for the sample statistics and percentile block
// no dependencies
package sps_pkg;

  localparam int DEF_STORE_DEPTH  = 1024;
  localparam int DEF_SAMPLE_WIDTH = 32;

  localparam int FRAC_WIDTH  = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = 17'd65536;

  localparam int STATUS_WIDTH = 2;
  localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_BAD_FRAC = 2'd3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ----- rtl/sps_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sample_stats_percentile.sv -----
// sorted sample store with running min, max, sum, count and percentile queries
// depends on sps_pkg, sps_ram and sample_stats_percentile_defines.svh
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------------------------
//   request | req_valid | req_stall | opcode, sample_value, percentile_fraction
//   result  | rsp_valid | rsp_stall | percentile_value, minimum_seen, maximum_seen,
//           |           |           | sample_sum, sample_count, status
//
// an add moves each stored sample larger than the new one up one slot, then writes
// the new one; the insertion shift moves one entry a cycle through the ram's single
// write port. a query runs S_MUL, S_RANK, S_WAIT; a rejected request skips to S_DONE.
// reset clears count and statistics at once; the ram needs no clearing since only
// entries below the count are ever used. a stalled result waits in the output
// register while the next request is taken; req_stall is high while one is busy.
`include "sample_stats_percentile_defines.svh"

module sample_stats_percentile import sps_pkg::*; #(
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int ADDR_W  = $clog2(STORE_DEPTH),
  localparam int COUNT_W = $clog2(STORE_DEPTH + 1),
  localparam int SUM_W   = SAMPLE_WIDTH + ADDR_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
  input  logic [FRAC_WIDTH-1:0]          percentile_fraction,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic signed [SAMPLE_WIDTH-1:0] percentile_value,
  output logic signed [SAMPLE_WIDTH-1:0] minimum_seen,
  output logic signed [SAMPLE_WIDTH-1:0] maximum_seen,
  output logic signed [SUM_W-1:0]        sample_sum,
  output logic [COUNT_W-1:0]             sample_count,
  output logic [STATUS_WIDTH-1:0]        status
);

  localparam int PROD_W = FRAC_WIDTH + COUNT_W;
  localparam int RANK_W = COUNT_W + 1;

  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_PLACE,
    S_MUL,
    S_RANK,
    S_WAIT,
    S_DONE
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]             stored_count;
  logic signed [SAMPLE_WIDTH-1:0] running_min;
  logic signed [SAMPLE_WIDTH-1:0] running_max;
  logic signed [SUM_W-1:0]        running_sum;

  logic signed [SAMPLE_WIDTH-1:0] val;
  logic [ADDR_W-1:0]              idx;
  logic [FRAC_WIDTH-1:0]          frac;
  logic [PROD_W-1:0]              prod;
  logic signed [SAMPLE_WIDTH-1:0] pick;
  logic [STATUS_WIDTH-1:0]        res_status;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  logic                accept;
  logic                add_go;
  logic                store_full;
  logic                shift_more;
  logic [PROD_W:0]     rank_sum;
  logic [RANK_W-1:0]   rank;
  logic [RANK_W-1:0]   rank_clamp;
  logic [RANK_W-1:0]   rank_m1;
  logic signed [SUM_W-1:0] val_ext;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign store_full = (stored_count == COUNT_W'(STORE_DEPTH));
  assign add_go     = accept && (opcode == OP_ADD) && !store_full;
  assign shift_more = ($signed(ram_rdata) > val);
  assign val_ext    = SUM_W'(sample_value);

  // nearest rank: ceil(frac * count / 2^16), kept within the count
  assign rank_sum   = PROD_W'(prod) + (PROD_W + 1)'(FRAC_ONE - 1'b1);
  assign rank       = rank_sum[FRAC_SHIFT +: RANK_W];
  assign rank_clamp = (rank > RANK_W'(stored_count)) ? RANK_W'(stored_count) : rank;
  assign rank_m1    = rank_clamp - 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = val;
    ram_raddr = ADDR_W'(idx - 1'b1);
    case (state)
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_raddr = ADDR_W'(idx - 2'd2);
        if (shift_more) begin
          ram_wdata = ram_rdata;
        end
      end
      S_PLACE: ram_we = 1'b1;
      S_RANK:  ram_raddr = rank_m1[ADDR_W-1:0];
      default: ;
    endcase
  end

  sps_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      running_min  <= MOST_POS;
      running_max  <= MOST_NEG;
      running_sum  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      // S_DONE handles its own handoff of the output register
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pick       <= '0;
            res_status <= ST_OK;
            frac       <= percentile_fraction;
            val        <= sample_value;
            idx        <= stored_count[ADDR_W-1:0];
            if (opcode == OP_ADD) begin
              if (store_full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                stored_count <= stored_count + 1'b1;
                running_sum  <= running_sum + val_ext;
                if (sample_value > running_max) begin
                  running_max <= sample_value;
                end
                if (sample_value < running_min) begin
                  running_min <= sample_value;
                end
                state <= S_FETCH;
              end
            end else if (stored_count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else if (percentile_fraction == '0 || percentile_fraction > FRAC_ONE) begin
              res_status <= ST_BAD_FRAC;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_FETCH: begin
          state <= (idx == '0) ? S_PLACE : S_SHIFT;
        end
        S_SHIFT: begin
          // larger entry moved up one slot, keep walking down
          if (shift_more) begin
            idx   <= idx - 1'b1;
            state <= (idx == ADDR_W'(1)) ? S_PLACE : S_SHIFT;
          end else begin
            state <= S_DONE;
          end
        end
        S_PLACE: state <= S_DONE;
        S_MUL: begin
          prod  <= frac * stored_count;
          state <= S_RANK;
        end
        S_RANK: state <= S_WAIT;
        S_WAIT: begin
          pick  <= $signed(ram_rdata);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            percentile_value <= pick;
            minimum_seen     <= running_min;
            maximum_seen     <= running_max;
            sample_sum       <= running_sum;
            sample_count     <= stored_count;
            status           <= res_status;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SPS_ASSERT_ALWAYS(a_count_bound, stored_count <= COUNT_W'(STORE_DEPTH), "count above depth")
  `SPS_ASSERT_ALWAYS(a_ram_wr, !ram_we || state == S_SHIFT || state == S_PLACE, "stray write")
  `SPS_ASSERT_ALWAYS(a_min_max, stored_count == '0 || running_min <= running_max, "min above max")
  `SPS_ASSERT_NEXT(a_add_cnt, add_go, stored_count == $past(stored_count) + 1'b1, "add lost")

endmodule
